// ----- rtl/pcmrom_pkg.sv -----
// ----------------------------------------------------------------------------
// pcmrom_pkg
// Shared constants, tables and descramble functions for the sample ROM block.
// ----------------------------------------------------------------------------
package pcmrom_pkg;

	// Default configuration
	localparam int ROM_ADDR_BITS_DEF = 22;
	localparam int MAX_RUN_DEF       = 64;

	// Fixed field widths
	localparam int INDEX_W  = 20;
	localparam int PART_W   = 2;
	localparam int BYTE_W   = 8;
	localparam int SADDR_W  = 23;
	localparam int COUNT_W  = 7;
	localparam int SAMPLE_W = 31;
	localparam int BANK_W   = 3;

	// Request opcodes
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_FETCH = 1'b1;

	// Bank ids that map onto the ROM
	localparam logic [BANK_W-1:0] BANK_ID_LOW  = 3'd0;
	localparam logic [BANK_W-1:0] BANK_ID_MIDA = 3'd1;
	localparam logic [BANK_W-1:0] BANK_ID_MIDB = 3'd2;
	localparam logic [BANK_W-1:0] BANK_ID_HIGH = 3'd4;

	// Megabyte slot each bank maps to
	localparam logic [1:0] SLOT_LOW  = 2'd0;
	localparam logic [1:0] SLOT_MID  = 2'd1;
	localparam logic [1:0] SLOT_HIGH = 2'd2;

	// Positions below this are stored unscrambled
	localparam logic [INDEX_W-1:0] SCRAMBLE_MIN = 20'h00020;

	// Fixed left shift applied to every sample
	localparam logic [4:0] SAMPLE_SHIFT = 5'd14;

	localparam logic [4:0] ADDR_PERM [INDEX_W] = '{
		5'd2, 5'd0, 5'd3, 5'd4, 5'd1, 5'd9, 5'd13, 5'd10, 5'd18, 5'd17,
		5'd6, 5'd15, 5'd11, 5'd16, 5'd8, 5'd5, 5'd12, 5'd7, 5'd14, 5'd19
	};

	localparam logic [2:0] DATA_PERM [BYTE_W] = '{
		3'd2, 3'd0, 3'd4, 3'd5, 3'd7, 3'd6, 3'd3, 3'd1
	};

	// Permute the position bits of a scrambled byte
	function automatic logic [INDEX_W-1:0] descramble_addr(input logic [INDEX_W-1:0] a);
		logic [INDEX_W-1:0] r;
		r = a;
		if (a >= SCRAMBLE_MIN) begin
			for (int b = 0; b < INDEX_W; b++) begin
				r[b] = a[ADDR_PERM[b]];
			end
		end
		return r;
	endfunction

	// Permute the data bits of a scrambled byte
	function automatic logic [BYTE_W-1:0] descramble_data(input logic [BYTE_W-1:0] d);
		logic [BYTE_W-1:0] r;
		r = '0;
		for (int b = 0; b < BYTE_W; b++) begin
			r[b] = d[DATA_PERM[b]];
		end
		return r;
	endfunction

endpackage

// ----- rtl/pcm_rom_descramble_sample_fetch.sv -----
// ----------------------------------------------------------------------------
// pcm_rom_descramble_sample_fetch
// Sample ROM with descrambling loader and banked sample fetch.
// ----------------------------------------------------------------------------
// Load: one request per cycle, byte written one cycle after acceptance.
// Fetch: each sample passes the ROM read register and the output register;
// one sample per cycle while the output is not stalled, paced by the
// two-port ROM read. Input stalls until all reads of the run have issued
// (one on a bad bank, none on a zero count), longer while output stalls.
// Reset clears sequencer and output valid; ROM contents are not cleared.
// ----------------------------------------------------------------------------
module pcm_rom_descramble_sample_fetch import pcmrom_pkg::*; #(
	parameter int ROM_ADDR_BITS = ROM_ADDR_BITS_DEF,
	parameter int MAX_RUN       = MAX_RUN_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       op,
	input  logic [PART_W-1:0]          rom_part,
	input  logic [INDEX_W-1:0]         byte_index,
	input  logic [BYTE_W-1:0]          rom_byte,
	input  logic [SADDR_W-1:0]         sample_address,
	input  logic [COUNT_W-1:0]         sample_count,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [SAMPLE_W-1:0] sample,
	output logic                       last,
	output logic                       error
);

	logic                     busy;
	logic                     accept;
	logic                     wr_en;
	logic [ROM_ADDR_BITS-1:0] wr_addr;
	logic [BYTE_W-1:0]        wr_data;
	logic                     rd_en;
	logic [ROM_ADDR_BITS-1:0] rd_addr_a;
	logic [ROM_ADDR_BITS-1:0] rd_addr_b;
	logic [BYTE_W-1:0]        rd_data_a;
	logic [BYTE_W-1:0]        rd_data_b;

	// Hold requests while a run is in progress
	assign in_stall = busy;
	assign accept   = in_valid && !busy;

	pcmrom_loader #(
		.ROM_ADDR_BITS(ROM_ADDR_BITS)
	) u_loader (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept && op == OP_LOAD),
		.rom_part  (rom_part),
		.byte_index(byte_index),
		.rom_byte  (rom_byte),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data)
	);

	pcmrom_mem #(
		.ROM_ADDR_BITS(ROM_ADDR_BITS)
	) u_mem (
		.clk      (clk),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_en    (rd_en),
		.rd_addr_a(rd_addr_a),
		.rd_addr_b(rd_addr_b),
		.rd_data_a(rd_data_a),
		.rd_data_b(rd_data_b)
	);

	pcmrom_fetch #(
		.ROM_ADDR_BITS(ROM_ADDR_BITS),
		.MAX_RUN      (MAX_RUN)
	) u_fetch (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (accept && op == OP_FETCH),
		.sample_address(sample_address),
		.sample_count  (sample_count),
		.busy          (busy),
		.rd_en         (rd_en),
		.rd_addr_a     (rd_addr_a),
		.rd_addr_b     (rd_addr_b),
		.rd_data_a     (rd_data_a),
		.rd_data_b     (rd_data_b),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.sample        (sample),
		.last          (last),
		.error         (error)
	);

endmodule

// ----- rtl/pcmrom_loader.sv -----
// ----------------------------------------------------------------------------
// pcmrom_loader
// Descrambles one load request and registers the ROM write it causes.
// ----------------------------------------------------------------------------
module pcmrom_loader import pcmrom_pkg::*; #(
	parameter int ROM_ADDR_BITS = ROM_ADDR_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     load,
	input  logic [PART_W-1:0]        rom_part,
	input  logic [INDEX_W-1:0]       byte_index,
	input  logic [BYTE_W-1:0]        rom_byte,
	output logic                     wr_en,
	output logic [ROM_ADDR_BITS-1:0] wr_addr,
	output logic [BYTE_W-1:0]        wr_data
);

	logic                     wr_en_q;
	logic [ROM_ADDR_BITS-1:0] wr_addr_q;
	logic [BYTE_W-1:0]        wr_data_q;
	logic [INDEX_W-1:0]       pos_d;
	logic [BYTE_W-1:0]        byte_d;

	// Unscramble position and data
	always_comb begin
		pos_d  = descramble_addr(byte_index);
		byte_d = (byte_index >= SCRAMBLE_MIN) ? descramble_data(rom_byte) : rom_byte;
	end

	// Hold the write strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_en_q <= 1'b0;
		end else begin
			wr_en_q <= load;
		end
	end

	// Capture write address and data
	always_ff @(posedge clk) begin
		if (load) begin
			wr_addr_q <= ROM_ADDR_BITS'({rom_part, pos_d});
			wr_data_q <= byte_d;
		end
	end

	assign wr_en   = wr_en_q;
	assign wr_addr = wr_addr_q;
	assign wr_data = wr_data_q;

endmodule

// ----- rtl/pcmrom_mem.sv -----
// ----------------------------------------------------------------------------
// pcmrom_mem
// Sample ROM store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module pcmrom_mem import pcmrom_pkg::*; #(
	parameter int ROM_ADDR_BITS = ROM_ADDR_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [ROM_ADDR_BITS-1:0] wr_addr,
	input  logic [BYTE_W-1:0]        wr_data,
	input  logic                     rd_en,
	input  logic [ROM_ADDR_BITS-1:0] rd_addr_a,
	input  logic [ROM_ADDR_BITS-1:0] rd_addr_b,
	output logic [BYTE_W-1:0]        rd_data_a,
	output logic [BYTE_W-1:0]        rd_data_b
);

	localparam int DEPTH = 2 ** ROM_ADDR_BITS;

	logic [BYTE_W-1:0] mem [DEPTH];
	logic [BYTE_W-1:0] rd_data_a_q;
	logic [BYTE_W-1:0] rd_data_b_q;

	// Write one byte
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read two bytes; hold the data while not enabled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a_q <= mem[rd_addr_a];
			rd_data_b_q <= mem[rd_addr_b];
		end
	end

	assign rd_data_a = rd_data_a_q;
	assign rd_data_b = rd_data_b_q;

endmodule

// ----- rtl/pcmrom_fetch.sv -----
// ----------------------------------------------------------------------------
// pcmrom_fetch
// Fetch sequencer: maps the bank, walks the run, issues ROM reads and
// scales each sample into the output register.
// ----------------------------------------------------------------------------
module pcmrom_fetch import pcmrom_pkg::*; #(
	parameter int ROM_ADDR_BITS = ROM_ADDR_BITS_DEF,
	parameter int MAX_RUN       = MAX_RUN_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [SADDR_W-1:0]         sample_address,
	input  logic [COUNT_W-1:0]         sample_count,
	output logic                       busy,
	output logic                       rd_en,
	output logic [ROM_ADDR_BITS-1:0]   rd_addr_a,
	output logic [ROM_ADDR_BITS-1:0]   rd_addr_b,
	input  logic [BYTE_W-1:0]          rd_data_a,
	input  logic [BYTE_W-1:0]          rd_data_b,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [SAMPLE_W-1:0] sample,
	output logic                       last,
	output logic                       error
);

	localparam int RW = $clog2(MAX_RUN + 1);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} fetch_state_t;

	fetch_state_t             state_q;
	logic [ROM_ADDR_BITS-1:0] addr_q;
	logic [RW-1:0]            remain_q;
	logic                     err_q;

	logic                     v_s1;
	logic                     last_s1;
	logic                     err_s1;
	logic                     hi_s1;

	logic                     out_v_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic                     last_q;
	logic                     error_q;

	logic [BANK_W-1:0]        bank_id;
	logic                     bank_ok;
	logic [1:0]               slot;
	logic [COUNT_W-1:0]       count_clamp;
	logic                     issue;
	logic                     adv_s1;
	logic                     final_issue;
	logic [3:0]               nib;
	logic [31:0]              scaled;

	// Map bank id onto a megabyte slot
	always_comb begin
		bank_id = sample_address[SADDR_W-1:INDEX_W];
		bank_ok = 1'b1;
		slot    = SLOT_LOW;
		unique case (bank_id)
			BANK_ID_LOW:                slot = SLOT_LOW;
			BANK_ID_MIDA, BANK_ID_MIDB: slot = SLOT_MID;
			BANK_ID_HIGH:               slot = SLOT_HIGH;
			default:                    bank_ok = 1'b0;
		endcase
		count_clamp = (sample_count > COUNT_W'(MAX_RUN)) ? COUNT_W'(MAX_RUN) : sample_count;
	end

	// Issue a read when stage one is free or moving on
	assign adv_s1      = v_s1 && (!out_v_q || !out_stall);
	assign issue       = (state_q == ST_RUN) && (!v_s1 || adv_s1);
	assign final_issue = (remain_q == RW'(1));

	// Sequence the run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			remain_q <= '0;
			err_q    <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						err_q <= !bank_ok;
						if (!bank_ok) begin
							remain_q <= RW'(1);
							state_q  <= ST_RUN;
						end else if (count_clamp != '0) begin
							remain_q <= RW'(count_clamp);
							state_q  <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					if (issue) begin
						remain_q <= remain_q - RW'(1);
						if (final_issue) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Load and advance the sample address
	always_ff @(posedge clk) begin
		if (start && state_q == ST_IDLE) begin
			addr_q <= ROM_ADDR_BITS'({slot, sample_address[INDEX_W-1:0]});
		end else if (issue) begin
			addr_q <= addr_q + ROM_ADDR_BITS'(1);
		end
	end

	// Data byte at the address, nibble byte from the bank's shift table
	assign rd_en     = issue;
	assign rd_addr_a = addr_q;
	assign rd_addr_b = {addr_q[ROM_ADDR_BITS-1:INDEX_W], 5'b0, addr_q[INDEX_W-1:5]};

	// Track reads in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (issue) begin
			v_s1 <= 1'b1;
		end else if (adv_s1) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			last_s1 <= final_issue;
			err_s1  <= err_q;
			hi_s1   <= addr_q[4];
		end
	end

	// Scale the signed byte by the selected nibble plus the fixed shift
	always_comb begin
		nib    = hi_s1 ? rd_data_b[7:4] : rd_data_b[3:0];
		scaled = {{(32 - BYTE_W){rd_data_a[BYTE_W-1]}}, rd_data_a} << ({1'b0, nib} + SAMPLE_SHIFT);
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv_s1) begin
			out_v_q <= 1'b1;
		end else if (!out_stall) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			sample_q <= err_s1 ? '0 : $signed(scaled[31:1]);
			last_q   <= last_s1;
			error_q  <= err_s1;
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign out_valid = out_v_q;
	assign sample    = sample_q;
	assign last      = last_q;
	assign error     = error_q;

endmodule

// ----- rtl/pcmrom_checker.sv -----
// ----------------------------------------------------------------------------
// pcmrom_checker
// Port-level checks on request intake and result delivery.
// ----------------------------------------------------------------------------
module pcmrom_checker import pcmrom_pkg::*; (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic                       op,
	input logic [SADDR_W-1:0]         sample_address,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic signed [SAMPLE_W-1:0] sample,
	input logic                       last,
	input logic                       error
);

	logic bad_bank;

	assign bad_bank = sample_address[SADDR_W-1:INDEX_W] != BANK_ID_LOW
		&& sample_address[SADDR_W-1:INDEX_W] != BANK_ID_MIDA
		&& sample_address[SADDR_W-1:INDEX_W] != BANK_ID_MIDB
		&& sample_address[SADDR_W-1:INDEX_W] != BANK_ID_HIGH;

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(sample) && $stable(last)
			&& $stable(error))
		else $error("stalled result changed");

	// An error result is a lone, zero, final result
	a_err_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error |-> last && sample == '0)
		else $error("error result malformed");

	// A bad bank fetch always occupies the sequencer
	a_bad_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && op == OP_FETCH && bad_bank |=> in_stall)
		else $error("bad bank fetch did not stall intake");

	// Loads never stall the next request
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && op == OP_LOAD |=> !in_stall)
		else $error("load stalled intake");

endmodule

bind pcm_rom_descramble_sample_fetch pcmrom_checker u_pcmrom_checker (.*);
